// File: src/jfe_pkg.sv
`default_nettype none

package jfe_pkg;

    localparam logic [7:0] FLAG_BYTE = 8'h7e;
    localparam logic [7:0] ESC_BYTE  = 8'h7d;
    localparam logic [7:0] ESC_FLAG  = 8'h02;
    localparam logic [7:0] ESC_ESC   = 8'h01;

    localparam int unsigned STEP_W = 5;
    localparam logic [STEP_W-1:0] STEP_FLAG_OPEN = 5'd0;
    localparam logic [STEP_W-1:0] STEP_DATA      = 5'd17;

    typedef struct packed {
        logic        first_item;
        logic [15:0] message_id;
        logic [9:0]  body_length;
        logic [15:0] part_count;
        logic [15:0] part_number;
        logic        has_byte;
        logic [7:0]  data_byte;
        logic        last_item;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       frame_end;
    } out_item_t;

    // byte source selected by a microinstruction
    typedef enum logic [4:0] {
        SRC_FLAG, SRC_ID_HI, SRC_ID_LO, SRC_PROP_HI, SRC_PROP_LO,
        SRC_TN5, SRC_TN4, SRC_TN3, SRC_TN2, SRC_TN1, SRC_TN0,
        SRC_SER_HI, SRC_SER_LO, SRC_PC_HI, SRC_PC_LO, SRC_PN_HI, SRC_PN_LO,
        SRC_DATA, SRC_CHECK
    } src_t;

    typedef enum logic {
        COND_ALWAYS,
        COND_HAS
    } cond_t;

    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_SINGLE,
        JMP_NOT_LAST,
        JMP_DONE
    } jmp_t;

    // when the byte of this step is the last one of the request
    typedef enum logic [2:0] {
        FIN_NO,
        FIN_YES,
        FIN_NO_TAIL,
        FIN_SINGLE_NO_TAIL,
        FIN_NO_LAST
    } fin_t;

    typedef struct packed {
        src_t  src;
        cond_t cond;
        logic  checked;
        logic  escaped;
        jmp_t  jmp;
        fin_t  fin;
        logic  frame_open;
        logic  frame_close;
        logic  inc_serial;
    } uword_t;

    typedef struct packed {
        logic valid;
        src_t src;
        logic checked;
        logic escaped;
        logic fin;
        logic frame_open;
        logic frame_close;
        logic inc_serial;
    } emit_t;

    // control store
    function automatic uword_t ucode(input logic [STEP_W-1:0] step);
        uword_t w;
        w = '{SRC_FLAG, COND_ALWAYS, 1'b0, 1'b0, JMP_DONE, FIN_NO, 1'b0, 1'b0, 1'b0};
        case (step)
            5'd0:  w = '{SRC_FLAG,    COND_ALWAYS, 1'b0, 1'b0, JMP_NEXT, FIN_NO,
                         1'b1, 1'b0, 1'b0};
            5'd1:  w = '{SRC_ID_HI,   COND_ALWAYS, 1'b1, 1'b1, JMP_NEXT, FIN_NO,
                         1'b0, 1'b0, 1'b0};
            5'd2:  w = '{SRC_ID_LO,   COND_ALWAYS, 1'b1, 1'b1, JMP_NEXT, FIN_NO,
                         1'b0, 1'b0, 1'b0};
            5'd3:  w = '{SRC_PROP_HI, COND_ALWAYS, 1'b1, 1'b1, JMP_NEXT, FIN_NO,
                         1'b0, 1'b0, 1'b0};
            5'd4:  w = '{SRC_PROP_LO, COND_ALWAYS, 1'b1, 1'b1, JMP_NEXT, FIN_NO,
                         1'b0, 1'b0, 1'b0};
            5'd5:  w = '{SRC_TN5,     COND_ALWAYS, 1'b1, 1'b1, JMP_NEXT, FIN_NO,
                         1'b0, 1'b0, 1'b0};
            5'd6:  w = '{SRC_TN4,     COND_ALWAYS, 1'b1, 1'b1, JMP_NEXT, FIN_NO,
                         1'b0, 1'b0, 1'b0};
            5'd7:  w = '{SRC_TN3,     COND_ALWAYS, 1'b1, 1'b1, JMP_NEXT, FIN_NO,
                         1'b0, 1'b0, 1'b0};
            5'd8:  w = '{SRC_TN2,     COND_ALWAYS, 1'b1, 1'b1, JMP_NEXT, FIN_NO,
                         1'b0, 1'b0, 1'b0};
            5'd9:  w = '{SRC_TN1,     COND_ALWAYS, 1'b1, 1'b1, JMP_NEXT, FIN_NO,
                         1'b0, 1'b0, 1'b0};
            5'd10: w = '{SRC_TN0,     COND_ALWAYS, 1'b1, 1'b1, JMP_NEXT, FIN_NO,
                         1'b0, 1'b0, 1'b0};
            5'd11: w = '{SRC_SER_HI,  COND_ALWAYS, 1'b1, 1'b1, JMP_NEXT, FIN_NO,
                         1'b0, 1'b0, 1'b0};
            5'd12: w = '{SRC_SER_LO,  COND_ALWAYS, 1'b1, 1'b1, JMP_SINGLE,
                         FIN_SINGLE_NO_TAIL, 1'b0, 1'b0, 1'b1};
            5'd13: w = '{SRC_PC_HI,   COND_ALWAYS, 1'b1, 1'b1, JMP_NEXT, FIN_NO,
                         1'b0, 1'b0, 1'b0};
            5'd14: w = '{SRC_PC_LO,   COND_ALWAYS, 1'b1, 1'b1, JMP_NEXT, FIN_NO,
                         1'b0, 1'b0, 1'b0};
            5'd15: w = '{SRC_PN_HI,   COND_ALWAYS, 1'b1, 1'b1, JMP_NEXT, FIN_NO,
                         1'b0, 1'b0, 1'b0};
            5'd16: w = '{SRC_PN_LO,   COND_ALWAYS, 1'b1, 1'b1, JMP_NEXT, FIN_NO_TAIL,
                         1'b0, 1'b0, 1'b0};
            5'd17: w = '{SRC_DATA,    COND_HAS,    1'b1, 1'b1, JMP_NOT_LAST, FIN_NO_LAST,
                         1'b0, 1'b0, 1'b0};
            5'd18: w = '{SRC_CHECK,   COND_ALWAYS, 1'b0, 1'b1, JMP_NEXT, FIN_NO,
                         1'b0, 1'b0, 1'b0};
            5'd19: w = '{SRC_FLAG,    COND_ALWAYS, 1'b0, 1'b0, JMP_DONE, FIN_YES,
                         1'b0, 1'b1, 1'b0};
            default: w = '{SRC_FLAG, COND_ALWAYS, 1'b0, 1'b0, JMP_DONE, FIN_NO,
                           1'b0, 1'b0, 1'b0};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// File: src/jtt808_frame_encoder.sv
`default_nettype none

// Message framer: flag, escaped header, escaped body, escaped XOR check, flag.
// Channels: in (valid/ready, in_item_t), one request per body byte; a request
// with first_item opens a frame and produces the flag and header first.
// cfg (valid/ready, always ready) loads the 48-bit terminal number; write it
// only while the framer is idle. out (valid/ready, out_item_t) gives one
// byte per transfer, run_last marking the final byte of each request and
// frame_end the closing flag.
// A microprogram of 20 steps emits one unescaped byte per cycle while the
// receiver keeps up; an escaped byte holds the sequencer until its second
// byte has moved to the output register. A plain body request is accepted
// and runs one step; a header request runs 14 steps (18 with part fields),
// counting its body step, and a closing request adds 2 steps.
// The first byte appears in the cycle after its step. A request is accepted
// only when the sequencer has finished the previous one.
// When the receiver stalls, the output register and one escape holding
// register fill and the sequencer waits on its current step.
// Reset clears the serial counter, check byte, frame state, terminal number
// and empties the output.
module jtt808_frame_encoder (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire jfe_pkg::in_item_t  in_data,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [47:0]        cfg_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output jfe_pkg::out_item_t      out_data
);

    logic [47:0]       terminal_reg, terminal_next;
    jfe_pkg::emit_t    emit;
    jfe_pkg::in_item_t item;
    logic              emit_ready;

    assign cfg_ready     = 1'b1;
    assign terminal_next = (cfg_valid && cfg_ready) ? cfg_data : terminal_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            terminal_reg <= '0;
        else
            terminal_reg <= terminal_next;
    end

    jfe_sequencer u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .emit_ready (emit_ready),
        .emit       (emit),
        .item       (item)
    );

    jfe_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .emit       (emit),
        .item       (item),
        .terminal   (terminal_reg),
        .emit_ready (emit_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule

`default_nettype wire

// File: src/jfe_sequencer.sv
`default_nettype none

module jfe_sequencer (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire jfe_pkg::in_item_t in_data,
    input  wire logic              emit_ready,
    output jfe_pkg::emit_t         emit,
    output jfe_pkg::in_item_t      item
);

    logic                           busy_reg, busy_next;
    logic [jfe_pkg::STEP_W-1:0]     step_reg, step_next;
    logic                           in_frame_reg, in_frame_next;
    jfe_pkg::in_item_t              item_reg, item_next;
    jfe_pkg::uword_t                word;
    logic                           cond_ok;
    logic                           single;
    logic                           no_tail;
    logic                           fin;
    logic                           advance;
    logic                           accept;

    assign word     = jfe_pkg::ucode(step_reg);
    assign in_ready = !busy_reg;
    assign accept   = in_valid && in_ready;
    assign single   = !(item_reg.part_count > 16'd1);
    assign no_tail  = !item_reg.has_byte && !item_reg.last_item;
    assign cond_ok  = (word.cond == jfe_pkg::COND_ALWAYS) || item_reg.has_byte;
    assign advance  = busy_reg && (!cond_ok || emit_ready);
    assign item     = item_reg;

    always_comb
    begin
        case (word.fin)
            jfe_pkg::FIN_NO:             fin = 1'b0;
            jfe_pkg::FIN_YES:            fin = 1'b1;
            jfe_pkg::FIN_NO_TAIL:        fin = no_tail;
            jfe_pkg::FIN_SINGLE_NO_TAIL: fin = single && no_tail;
            jfe_pkg::FIN_NO_LAST:        fin = !item_reg.last_item;
            default:                     fin = 1'b0;
        endcase
        emit.valid       = busy_reg && cond_ok;
        emit.src         = word.src;
        emit.checked     = word.checked;
        emit.escaped     = word.escaped;
        emit.fin         = fin;
        emit.frame_open  = word.frame_open;
        emit.frame_close = word.frame_close;
        emit.inc_serial  = word.inc_serial;
    end

    always_comb
    begin
        busy_next     = busy_reg;
        step_next     = step_reg;
        in_frame_next = in_frame_reg;
        item_next     = item_reg;
        if (accept)
        begin
            item_next = in_data;
            if (in_data.first_item)
            begin
                busy_next = 1'b1;
                step_next = jfe_pkg::STEP_FLAG_OPEN;
            end
            else if (in_frame_reg)
            begin
                busy_next = 1'b1;
                step_next = jfe_pkg::STEP_DATA;
            end
        end
        else if (advance)
        begin
            if (cond_ok && word.frame_open)
                in_frame_next = 1'b1;
            if (cond_ok && word.frame_close)
                in_frame_next = 1'b0;
            case (word.jmp)
                jfe_pkg::JMP_NEXT:
                    step_next = step_reg + 5'd1;
                jfe_pkg::JMP_SINGLE:
                    step_next = single ? jfe_pkg::STEP_DATA : step_reg + 5'd1;
                jfe_pkg::JMP_NOT_LAST:
                begin
                    if (item_reg.last_item)
                        step_next = step_reg + 5'd1;
                    else
                        busy_next = 1'b0;
                end
                jfe_pkg::JMP_DONE:
                    busy_next = 1'b0;
                default:
                    busy_next = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            step_reg     <= '0;
            in_frame_reg <= 1'b0;
        end
        else
        begin
            busy_reg     <= busy_next;
            step_reg     <= step_next;
            in_frame_reg <= in_frame_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    // a non-opening request outside a frame produces nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !in_data.first_item && !in_frame_reg) |=> !busy_reg)
        else $error("stray request started the sequencer");

endmodule

`default_nettype wire

// File: src/jfe_datapath.sv
`default_nettype none

module jfe_datapath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire jfe_pkg::emit_t    emit,
    input  wire jfe_pkg::in_item_t item,
    input  wire logic [47:0]       terminal,
    output logic                   emit_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output jfe_pkg::out_item_t     out_data
);

    logic [15:0]        serial_reg, serial_next;
    logic [7:0]         check_reg, check_next;
    logic               out_valid_reg, out_valid_next;
    jfe_pkg::out_item_t out_data_reg, out_data_next;
    logic               pend_valid_reg, pend_valid_next;
    jfe_pkg::out_item_t pend_data_reg, pend_data_next;
    logic [15:0]        prop;
    logic [7:0]         raw;
    logic               esc_hit;
    logic               take;
    logic               out_free;

    assign prop = {2'b00, (item.part_count > 16'd1), 3'b000, item.body_length};

    always_comb
    begin
        case (emit.src)
            jfe_pkg::SRC_FLAG:    raw = jfe_pkg::FLAG_BYTE;
            jfe_pkg::SRC_ID_HI:   raw = item.message_id[15:8];
            jfe_pkg::SRC_ID_LO:   raw = item.message_id[7:0];
            jfe_pkg::SRC_PROP_HI: raw = prop[15:8];
            jfe_pkg::SRC_PROP_LO: raw = prop[7:0];
            jfe_pkg::SRC_TN5:     raw = terminal[47:40];
            jfe_pkg::SRC_TN4:     raw = terminal[39:32];
            jfe_pkg::SRC_TN3:     raw = terminal[31:24];
            jfe_pkg::SRC_TN2:     raw = terminal[23:16];
            jfe_pkg::SRC_TN1:     raw = terminal[15:8];
            jfe_pkg::SRC_TN0:     raw = terminal[7:0];
            jfe_pkg::SRC_SER_HI:  raw = serial_reg[15:8];
            jfe_pkg::SRC_SER_LO:  raw = serial_reg[7:0];
            jfe_pkg::SRC_PC_HI:   raw = item.part_count[15:8];
            jfe_pkg::SRC_PC_LO:   raw = item.part_count[7:0];
            jfe_pkg::SRC_PN_HI:   raw = item.part_number[15:8];
            jfe_pkg::SRC_PN_LO:   raw = item.part_number[7:0];
            jfe_pkg::SRC_DATA:    raw = item.data_byte;
            jfe_pkg::SRC_CHECK:   raw = check_reg;
            default:              raw = jfe_pkg::FLAG_BYTE;
        endcase
    end

    assign esc_hit    = emit.escaped && (raw inside {jfe_pkg::FLAG_BYTE, jfe_pkg::ESC_BYTE});
    assign out_free   = !out_valid_reg || out_ready;
    assign emit_ready = !pend_valid_reg && out_free;
    assign take       = emit.valid && emit_ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        pend_valid_next = pend_valid_reg;
        pend_data_next  = pend_data_reg;
        serial_next     = serial_reg;
        check_next      = check_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
            if (esc_hit)
            begin
                // send the escape now, hold the second byte
                out_data_next   = '{jfe_pkg::ESC_BYTE, 1'b0, 1'b0};
                pend_valid_next = 1'b1;
                pend_data_next  = '{(raw == jfe_pkg::FLAG_BYTE) ? jfe_pkg::ESC_FLAG
                                                                 : jfe_pkg::ESC_ESC,
                                    emit.fin, 1'b0};
            end
            else
            begin
                out_data_next = '{raw, emit.fin, emit.frame_close};
            end
            if (emit.frame_open || emit.frame_close)
                check_next = '0;
            else if (emit.checked)
                check_next = check_reg ^ raw;
            if (emit.inc_serial)
                serial_next = serial_reg + 16'd1;
        end
        else if (pend_valid_reg && out_free)
        begin
            out_valid_next  = 1'b1;
            out_data_next   = pend_data_reg;
            pend_valid_next = 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            serial_reg     <= '0;
            check_reg      <= '0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            serial_reg     <= serial_next;
            check_reg      <= check_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        pend_data_reg <= pend_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (out_valid_reg && out_data_reg.out_byte == jfe_pkg::ESC_BYTE))
        else $error("escaped byte pending without its escape in the output register");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.frame_end) |-> out_data_reg.run_last)
        else $error("closing flag not marked as last of its request");

    assert property (@(posedge clk) disable iff (!rst_n)
        (take && emit.inc_serial) |=> (serial_reg == $past(serial_reg) + 16'd1))
        else $error("serial counter did not advance after the header");

endmodule

`default_nettype wire

// File: tb/jtt808_frame_encoder_tb.sv
`timescale 1ns / 100ps

module jtt808_frame_encoder_tb;

    localparam logic [15:0] MULTI_PART_BIT = 16'h2000;
    localparam logic [15:0] LENGTH_MASK    = 16'h03ff;
    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_HOLD     = 400;
    localparam int CYCLE_LIMIT   = 200000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    jfe_pkg::in_item_t  in_data = '0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [47:0]        cfg_data = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    jfe_pkg::out_item_t out_data;

    // frame model state
    logic [47:0] terminal_model = '0;
    logic [15:0] serial_model = '0;
    logic [7:0]  xor_model = '0;
    logic        open_model = 1'b0;

    jfe_pkg::in_item_t  req_backlog[$];
    jfe_pkg::out_item_t frame_bytes_due[$];
    jfe_pkg::out_item_t step_bytes[$];

    int reqs_pushed = 0;
    int reqs_taken = 0;
    int mismatch_count = 0;
    int bytes_checked = 0;
    int frames_opened = 0;
    int multipart_frames = 0;
    int abandoned_frames = 0;
    int escapes_seen = 0;
    int cycle_count = 0;

    int burst_left = 1;
    int gap_left = 0;
    bit gapless = 1'b0;
    bit hold_arm = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;
    logic [7:0] stall_tick = '0;

    jtt808_frame_encoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void put_byte(input logic [7:0] b, input logic closing);
        jfe_pkg::out_item_t r;
        r.out_byte  = b;
        r.run_last  = 1'b0;
        r.frame_end = closing;
        step_bytes.push_back(r);
    endfunction

    function automatic void put_escaped(input logic [7:0] b);
        if (b == jfe_pkg::FLAG_BYTE)
        begin
            put_byte(jfe_pkg::ESC_BYTE, 1'b0);
            put_byte(jfe_pkg::ESC_FLAG, 1'b0);
            escapes_seen++;
        end
        else if (b == jfe_pkg::ESC_BYTE)
        begin
            put_byte(jfe_pkg::ESC_BYTE, 1'b0);
            put_byte(jfe_pkg::ESC_ESC, 1'b0);
            escapes_seen++;
        end
        else
            put_byte(b, 1'b0);
    endfunction

    function automatic void put_checked(input logic [7:0] b);
        xor_model = xor_model ^ b;
        put_escaped(b);
    endfunction

    function automatic void put_word(input logic [15:0] w);
        put_checked(w[15:8]);
        put_checked(w[7:0]);
    endfunction

    // Work out the bytes one accepted request produces and queue them.
    function automatic void frame_model_step(input jfe_pkg::in_item_t req);
        logic [15:0]        prop;
        jfe_pkg::out_item_t r;
        int                 k;
        step_bytes.delete();
        if (req.first_item)
        begin
            if (open_model)
                abandoned_frames++;
            prop = {6'b0, req.body_length} & LENGTH_MASK;
            if (req.part_count > 16'd1)
                prop = prop | MULTI_PART_BIT;
            xor_model  = '0;
            open_model = 1'b1;
            frames_opened++;
            put_byte(jfe_pkg::FLAG_BYTE, 1'b0);
            put_word(req.message_id);
            put_word(prop);
            for (k = 5; k >= 0; k--)
                put_checked(terminal_model[8*k +: 8]);
            put_word(serial_model);
            serial_model = serial_model + 16'd1;
            if (req.part_count > 16'd1)
            begin
                put_word(req.part_count);
                put_word(req.part_number);
                multipart_frames++;
            end
        end
        if (open_model)
        begin
            if (req.has_byte)
                put_checked(req.data_byte);
            if (req.last_item)
            begin
                put_escaped(xor_model);
                put_byte(jfe_pkg::FLAG_BYTE, 1'b1);
                open_model = 1'b0;
                xor_model  = '0;
            end
        end
        for (k = 0; k < step_bytes.size(); k++)
        begin
            r = step_bytes[k];
            if (k == step_bytes.size() - 1)
                r.run_last = 1'b1;
            frame_bytes_due.push_back(r);
        end
    endfunction

    function automatic void note_mismatch(input string what, input logic [7:0] want,
                                          input logic [7:0] got);
        $display("%0t: %s mismatch, expected %02h, got %02h", $time, what, want, got);
        mismatch_count++;
    endfunction

    // request driver: bursts with random gaps
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                frame_model_step(in_data);
                reqs_taken = reqs_taken + 1;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left != 0 && !gapless)
                begin
                    gap_left = gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (req_backlog.size() != 0)
                begin
                    in_data  <= req_backlog.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 10);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left = burst_left - 1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // byte monitor and receiver stall pattern
    always @(posedge clk)
    begin : byte_monitor
        jfe_pkg::out_item_t due;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (frame_bytes_due.size() == 0)
                begin
                    note_mismatch("unexpected byte", 8'h00, out_data.out_byte);
                end
                else
                begin
                    due = frame_bytes_due.pop_front();
                    if (out_data.out_byte !== due.out_byte)
                        note_mismatch("out_byte", due.out_byte, out_data.out_byte);
                    if (out_data.run_last !== due.run_last)
                        note_mismatch("run_last", {7'd0, due.run_last},
                                      {7'd0, out_data.run_last});
                    if (out_data.frame_end !== due.frame_end)
                        note_mismatch("frame_end", {7'd0, due.frame_end},
                                      {7'd0, out_data.frame_end});
                    bytes_checked++;
                end
            end
            if (hold_arm && !hold_done)
            begin
                hold_left = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (hold_left != 0)
            begin
                hold_left = hold_left - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                stall_tick = stall_tick + 8'd1;
                case (stall_tick[7:6])
                    2'd0:    out_ready <= 1'b1;
                    2'd1:    out_ready <= ($urandom_range(0, 1) == 1);
                    2'd2:    out_ready <= (stall_tick[1:0] == 2'b00);
                    default: out_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: run stalled with %0d bytes still due", $time,
                     frame_bytes_due.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic jfe_pkg::in_item_t junk_item();
        logic [95:0] r;
        r = {$urandom, $urandom, $urandom};
        return r[$bits(jfe_pkg::in_item_t)-1:0];
    endfunction

    function automatic logic [7:0] rand_byte();
        logic [31:0] r;
        r = $urandom;
        case (r[31:29])
            3'd0:    return jfe_pkg::FLAG_BYTE;
            3'd1:    return jfe_pkg::ESC_BYTE;
            default: return r[7:0];
        endcase
    endfunction

    function automatic jfe_pkg::in_item_t mk(input logic first, input logic [15:0] id,
                                             input logic [9:0] blen, input logic [15:0] pc,
                                             input logic [15:0] pn, input logic has,
                                             input logic [7:0] data, input logic last);
        jfe_pkg::in_item_t it;
        it.first_item  = first;
        it.message_id  = id;
        it.body_length = blen;
        it.part_count  = pc;
        it.part_number = pn;
        it.has_byte    = has;
        it.data_byte   = data;
        it.last_item   = last;
        return it;
    endfunction

    task automatic queue_req(input jfe_pkg::in_item_t it);
        req_backlog.push_back(it);
        reqs_pushed++;
    endtask

    task automatic wait_drained();
        while (reqs_taken != reqs_pushed || frame_bytes_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic settle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_terminal(input logic [47:0] value);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        terminal_model = value;
    endtask

    // Mostly well-formed frames with random content; some stray idle
    // requests and frames dropped without a closing request.
    task automatic gen_frames(input int count);
        int                made;
        int                nbody;
        int                k;
        logic              abandon;
        logic              left_open;
        logic [9:0]        blen;
        jfe_pkg::in_item_t it;
        made = 0;
        left_open = 1'b0;
        while (made < count)
        begin
            if (!left_open && $urandom_range(0, 9) == 0)
            begin
                it = junk_item();
                it.first_item = 1'b0;
                queue_req(it);
            end
            nbody = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(0, 5);
            abandon = ($urandom_range(0, 9) == 0);
            for (k = 0; k <= nbody; k++)
            begin
                it = junk_item();
                it.first_item = (k == 0);
                it.has_byte   = ($urandom_range(0, 6) != 0);
                it.data_byte  = rand_byte();
                it.last_item  = (k == nbody) && !abandon;
                if (k == 0)
                begin
                    blen = 10'(nbody);
                    it.message_id = {rand_byte(), rand_byte()};
                    if ($urandom_range(0, 2) != 0)
                        it.body_length = blen;
                    case ($urandom_range(0, 3))
                        0:       it.part_count = 16'd0;
                        1:       it.part_count = 16'd1;
                        2:       it.part_count = 16'd2;
                        default: it.part_count = {rand_byte(), rand_byte()};
                    endcase
                    it.part_number = {rand_byte(), rand_byte()};
                end
                queue_req(it);
                made++;
            end
            left_open = abandon;
        end
        if (left_open)
            queue_req(mk(1'b0, 16'h0, 10'h0, 16'h0, 16'h0, 1'b0, 8'h00, 1'b1));
    endtask

    initial
    begin : stimulus
        int                k;
        jfe_pkg::in_item_t it;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, idle and empty requests, restart, multi-part
        queue_req(mk(1'b1, 16'h0000, 10'h000, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b1));
        queue_req(mk(1'b1, 16'hffff, 10'h3ff, 16'h0001, 16'hffff, 1'b1, 8'h7e, 1'b0));
        queue_req(mk(1'b0, 16'hffff, 10'h3ff, 16'hffff, 16'hffff, 1'b1, 8'h7d, 1'b0));
        queue_req(mk(1'b0, 16'h0000, 10'h000, 16'h0000, 16'h0000, 1'b0, 8'hff, 1'b0));
        queue_req(mk(1'b0, 16'h0000, 10'h000, 16'h0000, 16'h0000, 1'b1, 8'h00, 1'b0));
        queue_req(mk(1'b0, 16'h0000, 10'h000, 16'h0000, 16'h0000, 1'b1, 8'hff, 1'b1));
        queue_req(mk(1'b0, 16'h1234, 10'h155, 16'h0003, 16'h0001, 1'b1, 8'h55, 1'b1));
        queue_req(mk(1'b0, 16'h0000, 10'h000, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0));
        queue_req(mk(1'b1, 16'h7e7d, 10'h37e, 16'h0002, 16'hffff, 1'b1, 8'h7e, 1'b0));
        queue_req(mk(1'b1, 16'h0102, 10'h17d, 16'hffff, 16'h7e7d, 1'b0, 8'h00, 1'b0));
        queue_req(mk(1'b0, 16'h0000, 10'h000, 16'h0000, 16'h0000, 1'b1, 8'ha5, 1'b0));
        queue_req(mk(1'b0, 16'h0000, 10'h000, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b1));
        queue_req(mk(1'b1, 16'h8001, 10'h200, 16'h0001, 16'h0000, 1'b1, 8'h7d, 1'b1));
        queue_req(mk(1'b1, 16'h7d7e, 10'h07e, 16'h7e7e, 16'h0001, 1'b0, 8'h00, 1'b1));
        // steer the check byte onto the flag and escape values
        queue_req(mk(1'b1, 16'h4242, 10'h001, 16'h0000, 16'h0000, 1'b1, 8'h33, 1'b0));
        wait_drained();
        queue_req(mk(1'b0, 16'h0000, 10'h000, 16'h0000, 16'h0000, 1'b1,
                     xor_model ^ jfe_pkg::FLAG_BYTE, 1'b1));
        queue_req(mk(1'b1, 16'h2424, 10'h001, 16'h0005, 16'h0004, 1'b0, 8'h00, 1'b0));
        wait_drained();
        queue_req(mk(1'b0, 16'h0000, 10'h000, 16'h0000, 16'h0000, 1'b1,
                     xor_model ^ jfe_pkg::ESC_BYTE, 1'b1));
        settle();

        write_terminal(48'hffff_ffff_ffff);
        gen_frames(22);
        settle();

        // long receiver hold while the sender keeps offering a long frame
        write_terminal(48'h7e7d_7e7d_7e7d);
        gapless = 1'b1;
        hold_arm = 1'b1;
        queue_req(mk(1'b1, 16'h7e7e, 10'h012, 16'h7d7d, 16'h7e7e, 1'b1, 8'h7e, 1'b0));
        for (k = 0; k < 18; k++)
        begin
            it = junk_item();
            it.first_item = 1'b0;
            it.has_byte   = 1'b1;
            it.data_byte  = (k % 3 == 0) ? jfe_pkg::FLAG_BYTE
                          : (k % 3 == 1) ? jfe_pkg::ESC_BYTE : rand_byte();
            it.last_item  = (k == 17);
            queue_req(it);
        end
        settle();
        gapless = 1'b0;

        write_terminal(48'({$urandom, $urandom}));
        // pause the sender in mid-frame until everything has drained
        queue_req(mk(1'b1, 16'h0200, 10'h006, 16'h0000, 16'h0000, 1'b1, rand_byte(), 1'b0));
        for (k = 0; k < 5; k++)
        begin
            if (k == 2)
                wait_drained();
            queue_req(mk(1'b0, 16'h0000, 10'h000, 16'h0000, 16'h0000, 1'b1, rand_byte(),
                         k == 4));
        end
        gen_frames(18);
        settle();

        write_terminal(48'h0);
        gen_frames(18);
        settle();

        $display("Sent %0d requests: %0d frames (%0d multi-part, %0d dropped open).",
                 reqs_taken, frames_opened, multipart_frames, abandoned_frames);
        $display("Checked %0d output bytes, %0d escaped values, 4 terminal numbers.",
                 bytes_checked, escapes_seen);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
